FILE: rtl/assert_macros.svh
// Assertion macros used by mu_law_loop_recorder.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge out of reset.
`define MLLR_ASSERT_ALWAYS(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define MLLR_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

FILE: rtl/mllr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mllr_pkg;

   localparam int LOOP_CAPACITY = 262144;
   localparam int POS_W = $clog2(LOOP_CAPACITY);
   localparam int LEN_W = POS_W + 1;

   localparam logic [14:0] NINE_TENTHS_Q15 = 15'd29491;
   localparam logic [15:0] MU_BIAS = 16'd132;
   localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;

   localparam logic [2:0] CSR_ADDR_W = 3'd3;

   typedef enum logic [1:0] {
      OP_IDLE,
      OP_PLAY,
      OP_REPLACE,
      OP_OVERDUB
   } opcode_type;

   function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] r;
      if (len == '0) begin
         r = LEN_W'(1);
      end else if (len > LEN_W'(LOOP_CAPACITY)) begin
         r = LEN_W'(LOOP_CAPACITY);
      end else begin
         r = len;
      end
      return r;
   endfunction

   function automatic logic [7:0] mu_encode(input logic signed [15:0] s);
      logic [15:0] abs_v;
      logic [15:0] biased;
      logic [14:0] mag;
      logic [2:0] ex;
      logic [14:0] shifted;
      abs_v = s[15] ? 16'(-s) : 16'(s);
      biased = abs_v + MU_BIAS;
      mag = (biased > 16'd32767) ? 15'h7FFF : biased[14:0];
      ex = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (mag[i + 7]) begin
            ex = 3'(i);
         end
      end
      shifted = mag >> ({1'b0, ex} + 4'd3);
      return ~{s[15], ex, shifted[3:0]};
   endfunction

   function automatic logic signed [15:0] mu_decode(input logic [7:0] code);
      logic [7:0] b;
      logic [15:0] m;
      b = ~code;
      m = ((16'({b[3:0], 3'b000}) + MU_BIAS) << b[6:4]) - MU_BIAS;
      return b[7] ? 16'(-$signed(m)) : $signed(m);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/mu_law_loop_recorder.sv
// Loop recorder that keeps one mu-law byte per loop position in a single-port-write,
// single-port-read RAM of LOOP_CAPACITY bytes. Each request transfer carries a live
// Q15 sample and an opcode (idle, play, replace, overdub) and yields exactly one
// response transfer; the position advances on every request and wraps at loop_length.
// One request is taken per clock cycle while the response side is not stalled: the RAM
// read is issued when the request is accepted, the decode, mix, re-encode and write-back
// happen in the stage that holds the request, as it advances to the response register,
// and a write to the position that the next request reads is forwarded. Stored entries
// are undefined until a record operation writes them; no clearing pass runs after reset.
// loop_length may be written only while no transfer is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mu_law_loop_recorder (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic signed [15:0]                  req_sample_in,
   input  wire logic [1:0]                          req_opcode,

   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic signed [15:0]                  rsp_sample_out,
   output      logic [mllr_pkg::POS_W-1:0]          rsp_position,
   output      logic                                rsp_loop_start,

   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [mllr_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [31:0]                         pwdata,
   output      logic [31:0]                         prdata,
   output      logic                                pready
);

   localparam int POS_W = mllr_pkg::POS_W;
   localparam int LEN_W = mllr_pkg::LEN_W;

   logic [7:0] store_mem [mllr_pkg::LOOP_CAPACITY];

   logic [LEN_W-1:0] loop_length_ff;
   logic [POS_W-1:0] position_ff;
   logic [POS_W-1:0] position_in;

   logic s1_valid_ff;
   logic [POS_W-1:0] s1_pos_ff;
   mllr_pkg::opcode_type s1_op_ff;
   logic signed [15:0] s1_sample_ff;
   logic [7:0] rdata_ff;
   logic fwd_ff;
   logic [7:0] fwd_byte_ff;

   logic rsp_valid_ff;
   logic signed [15:0] rsp_sample_out_ff;
   logic [POS_W-1:0] rsp_position_ff;
   logic rsp_loop_start_ff;

   logic accept;
   logic s1_adv;
   logic s1_write;
   logic cfg_write;
   logic [LEN_W-1:0] eff_len;
   logic [LEN_W-1:0] new_eff_len;
   logic [LEN_W-1:0] pos_plus;

   logic [7:0] old_byte;
   logic signed [15:0] old_val;
   logic signed [15:0] live;
   logic signed [16:0] sum_wide;
   logic signed [15:0] sum_sat;
   logic signed [15:0] enc_in;
   logic [7:0] new_byte;
   logic [14:0] play_mag;
   logic [29:0] play_prod;
   logic [14:0] play_scaled;
   logic signed [15:0] play_out;

   assign pready = 1'b1;
   assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign prdata = (paddr[2] == 1'b0) ? 32'(loop_length_ff) : 32'd0;

   assign eff_len = mllr_pkg::eff_length(loop_length_ff);
   assign new_eff_len = mllr_pkg::eff_length(pwdata[LEN_W-1:0]);

   assign s1_adv = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept = req_valid && req_ready;

   assign pos_plus = {1'b0, position_ff} + LEN_W'(1);

   always_comb begin
      position_in = position_ff;
      if (cfg_write) begin
         if ({1'b0, position_ff} >= new_eff_len) begin
            position_in = '0;
         end
      end else if (accept) begin
         position_in = (pos_plus >= eff_len) ? '0 : pos_plus[POS_W-1:0];
      end
   end

   always_comb begin
      old_byte = fwd_ff ? fwd_byte_ff : rdata_ff;
      old_val = mllr_pkg::mu_decode(old_byte);
      live = (s1_sample_ff == -16'sd32768) ? -mllr_pkg::SAMPLE_MAX : s1_sample_ff;
      sum_wide = 17'(old_val) + 17'(live);
      if (sum_wide > 17'(mllr_pkg::SAMPLE_MAX)) begin
         sum_sat = mllr_pkg::SAMPLE_MAX;
      end else if (sum_wide < -17'(mllr_pkg::SAMPLE_MAX)) begin
         sum_sat = -mllr_pkg::SAMPLE_MAX;
      end else begin
         sum_sat = sum_wide[15:0];
      end
      enc_in = (s1_op_ff == mllr_pkg::OP_REPLACE) ? live : sum_sat;
      new_byte = mllr_pkg::mu_encode(enc_in);
      play_mag = old_val[15] ? 15'(-old_val) : old_val[14:0];
      play_prod = 30'(play_mag) * 30'(mllr_pkg::NINE_TENTHS_Q15) + 30'd16384;
      play_scaled = play_prod[29:15];
      play_out = old_val[15] ? -$signed({1'b0, play_scaled}) : $signed({1'b0, play_scaled});
   end

   assign s1_write = s1_adv &&
      (s1_op_ff == mllr_pkg::OP_REPLACE || s1_op_ff == mllr_pkg::OP_OVERDUB);

   always_ff @(posedge clock) begin
      if (s1_write) begin
         store_mem[s1_pos_ff] <= new_byte;
      end
      if (accept) begin
         rdata_ff <= store_mem[position_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_length_ff <= LEN_W'(mllr_pkg::LOOP_CAPACITY);
         position_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_write) begin
            loop_length_ff <= pwdata[LEN_W-1:0];
         end
         position_ff <= position_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff <= position_ff;
         s1_op_ff <= mllr_pkg::opcode_type'(req_opcode);
         s1_sample_ff <= req_sample_in;
         fwd_ff <= s1_write && (s1_pos_ff == position_ff);
         fwd_byte_ff <= new_byte;
      end
      if (s1_adv) begin
         rsp_sample_out_ff <= (s1_op_ff == mllr_pkg::OP_PLAY) ? play_out : 16'sd0;
         rsp_position_ff <= s1_pos_ff;
         rsp_loop_start_ff <= (s1_pos_ff == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_loop_start = rsp_loop_start_ff;

   `MLLR_ASSERT_ALWAYS(a_position_in_loop, {1'b0, position_ff} < eff_len)
   `MLLR_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid_ff)
   `MLLR_ASSERT_NEXT(a_stalled_stage_holds, s1_valid_ff && !s1_adv,
      s1_valid_ff && $stable(s1_pos_ff) && $stable(s1_op_ff))

endmodule

`default_nettype wire
